### design/rlm_pkg.sv
`timescale 1ns / 1ps

package rlm_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 16;
   localparam int RATE_W     = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam int FILT_W    = 32;
   localparam int MAG_W     = 32;
   localparam int SUM_W     = 40;
   localparam int FLOOR_W   = 28;
   localparam int THRESH_W  = 33;
   localparam int ENV_W     = 16;
   localparam int LEVEL_W   = 8;
   localparam int OUT20_W   = 20;
   localparam int DIV_CNT_W = 6;

   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = 51;
   localparam int MUL_R_W = 40;
   localparam int SHIFT_RATE = 16;
   localparam int SHIFT_MULT = 12;

   localparam logic [ENV_W-1:0]  TARGET_MAX = 16'd65280;
   localparam logic [ENV_W-1:0]  LEVEL_RND  = 16'd128;
   localparam logic [RATE_W-1:0] RATE_ONE   = 17'd65536;

   localparam logic [COEF_W-1:0] RST_HIGHPASS_COEFF   = 16'd62259;
   localparam logic [COEF_W-1:0] RST_FLOOR_FALL_RATE  = 16'd3277;
   localparam logic [COEF_W-1:0] RST_FLOOR_RISE_RATE  = 16'd33;
   localparam logic [COEF_W-1:0] RST_FLOOR_MULTIPLIER = 16'd4506;
   localparam logic [COEF_W-1:0] RST_THRESHOLD_OFFSET = 16'd80;
   localparam logic [COEF_W-1:0] RST_LEVEL_GAIN       = 16'd6554;
   localparam logic [RATE_W-1:0] RST_ATTACK_RATE      = 17'd65536;
   localparam logic [RATE_W-1:0] RST_RELEASE_RATE     = 17'd29491;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HIGHPASS_COEFF   = 3'd0,
      CSR_FLOOR_FALL_RATE  = 3'd1,
      CSR_FLOOR_RISE_RATE  = 3'd2,
      CSR_FLOOR_MULTIPLIER = 3'd3,
      CSR_THRESHOLD_OFFSET = 3'd4,
      CSR_LEVEL_GAIN       = 3'd5,
      CSR_ATTACK_RATE      = 3'd6,
      CSR_RELEASE_RATE     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic                      start;
      logic                      shift16;
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                      valid;
      logic signed [MUL_R_W-1:0] value;
   } mul_rsp_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

### design/rlm_mul.sv
`timescale 1ns / 1ps

// shared multiply, round half up, arithmetic shift; product and rounded result are registered in turn
module rlm_mul (
   input  logic                clock,
   input  logic                reset,
   input  rlm_pkg::mul_req_type req,
   output rlm_pkg::mul_rsp_type rsp
);

   logic signed [rlm_pkg::MUL_P_W-1:0] prod_ff;
   logic                               shift16_ff;
   logic                               v1_ff;
   logic                               v2_ff;
   logic signed [rlm_pkg::MUL_R_W-1:0] value_ff;

   logic signed [rlm_pkg::MUL_P_W-1:0] rnd;
   logic signed [rlm_pkg::MUL_P_W-1:0] biased;
   logic signed [rlm_pkg::MUL_P_W-1:0] shifted;
   logic signed [rlm_pkg::MUL_P_W-1:0] prod_in;

   assign prod_in = req.a * req.b;
   assign rnd     = shift16_ff ? (rlm_pkg::MUL_P_W'(1) <<< (rlm_pkg::SHIFT_RATE - 1))
                               : (rlm_pkg::MUL_P_W'(1) <<< (rlm_pkg::SHIFT_MULT - 1));
   assign biased  = prod_ff + rnd;
   assign shifted = shift16_ff ? (biased >>> rlm_pkg::SHIFT_RATE)
                               : (biased >>> rlm_pkg::SHIFT_MULT);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= req.start;
         v2_ff <= v1_ff;
      end
      prod_ff    <= prod_in;
      shift16_ff <= req.shift16;
      value_ff   <= shifted[rlm_pkg::MUL_R_W-1:0];
   end

   assign rsp.valid = v2_ff;
   assign rsp.value = value_ff;

endmodule

### design/rlm_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module rlm_div #(
   parameter int DVS_W = 9
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [rlm_pkg::SUM_W-1:0] dividend,
   input  logic [DVS_W-1:0]          divisor,
   output rlm_pkg::div_rsp_type      rsp
);

   logic                          busy_ff;
   logic                          done_ff;
   logic [rlm_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [rlm_pkg::SUM_W-1:0]     quo_ff;
   logic [DVS_W-1:0]              rem_ff;
   logic [DVS_W-1:0]              dvs_ff;

   logic [DVS_W:0]   partial;
   logic [DVS_W:0]   diff;
   logic             fits;
   logic [DVS_W-1:0] rem_in;

   assign partial = {rem_ff, quo_ff[rlm_pkg::SUM_W-1]};
   assign diff    = partial - {1'b0, dvs_ff};
   assign fits    = partial >= {1'b0, dvs_ff};
   assign rem_in  = fits ? diff[DVS_W-1:0] : partial[DVS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[rlm_pkg::SUM_W-2:0], fits};
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == rlm_pkg::DIV_CNT_W'(rlm_pkg::SUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

### design/music_ring_level_meter.sv
`timescale 1ns / 1ps

// channel  direction  handshake            payload
// req      in         req_valid/req_stall  req_sample, req_last_in_chunk
// rsp      out        rsp_valid/rsp_stall  rsp_level, rsp_mean_magnitude, rsp_floor_level
// csr      in         csr_wr_en            csr_index, csr_wdata
//
// A sample that does not end its chunk is accepted, passes through the shared
// multiplier for the high-pass feedback, then goes through the accumulate step.
// The last sample of a chunk then goes through the 40-step divider for the mean and
// the shared multiplier for floor, threshold, target and envelope (target skipped
// when the mean is not above the threshold). Synchronous reset clears all filter,
// floor and envelope state. req_stall is high while an item is being worked on; a
// result waits in the output register under rsp_stall while the next item is taken.
module music_ring_level_meter #(
   parameter int MAX_CHUNK = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [rlm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_last_in_chunk,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rlm_pkg::LEVEL_W-1:0]         rsp_level,
   output logic [rlm_pkg::OUT20_W-1:0]         rsp_mean_magnitude,
   output logic [rlm_pkg::OUT20_W-1:0]         rsp_floor_level,
   input  logic                                csr_wr_en,
   input  logic [rlm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rlm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CNT_W = $clog2(MAX_CHUNK + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_FILT, ST_ACC, ST_DIVS, ST_DIV, ST_FLOOR, ST_FLOORW,
      ST_THR, ST_THRW, ST_TGT, ST_TGTW, ST_ENV, ST_ENVW, ST_OUT
   } state_type;

   // configuration
   logic [rlm_pkg::COEF_W-1:0] hp_coeff_ff;
   logic [rlm_pkg::COEF_W-1:0] fall_rate_ff;
   logic [rlm_pkg::COEF_W-1:0] rise_rate_ff;
   logic [rlm_pkg::COEF_W-1:0] floor_mult_ff;
   logic [rlm_pkg::COEF_W-1:0] offset_ff;
   logic [rlm_pkg::COEF_W-1:0] gain_ff;
   logic [rlm_pkg::RATE_W-1:0] attack_ff;
   logic [rlm_pkg::RATE_W-1:0] release_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hp_coeff_ff   <= rlm_pkg::RST_HIGHPASS_COEFF;
         fall_rate_ff  <= rlm_pkg::RST_FLOOR_FALL_RATE;
         rise_rate_ff  <= rlm_pkg::RST_FLOOR_RISE_RATE;
         floor_mult_ff <= rlm_pkg::RST_FLOOR_MULTIPLIER;
         offset_ff     <= rlm_pkg::RST_THRESHOLD_OFFSET;
         gain_ff       <= rlm_pkg::RST_LEVEL_GAIN;
         attack_ff     <= rlm_pkg::RST_ATTACK_RATE;
         release_ff    <= rlm_pkg::RST_RELEASE_RATE;
      end else if (csr_wr_en) begin
         unique case (rlm_pkg::csr_index_type'(csr_index))
            rlm_pkg::CSR_HIGHPASS_COEFF:   hp_coeff_ff   <= csr_wdata[rlm_pkg::COEF_W-1:0];
            rlm_pkg::CSR_FLOOR_FALL_RATE:  fall_rate_ff  <= csr_wdata[rlm_pkg::COEF_W-1:0];
            rlm_pkg::CSR_FLOOR_RISE_RATE:  rise_rate_ff  <= csr_wdata[rlm_pkg::COEF_W-1:0];
            rlm_pkg::CSR_FLOOR_MULTIPLIER: floor_mult_ff <= csr_wdata[rlm_pkg::COEF_W-1:0];
            rlm_pkg::CSR_THRESHOLD_OFFSET: offset_ff     <= csr_wdata[rlm_pkg::COEF_W-1:0];
            rlm_pkg::CSR_LEVEL_GAIN:       gain_ff       <= csr_wdata[rlm_pkg::COEF_W-1:0];
            rlm_pkg::CSR_ATTACK_RATE:      attack_ff     <= csr_wdata;
            rlm_pkg::CSR_RELEASE_RATE:     release_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer state
   state_type                          state_ff, state_in;
   logic signed [rlm_pkg::SAMPLE_W-1:0] x_ff, x_in;
   logic                               last_ff, last_in;
   logic signed [rlm_pkg::SAMPLE_W-1:0] prev_input_ff, prev_input_in;
   logic signed [rlm_pkg::FILT_W-1:0]   prev_filt_ff, prev_filt_in;
   logic [rlm_pkg::SUM_W-1:0]           sum_ff, sum_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [rlm_pkg::SUM_W-1:0]           mean_ff, mean_in;
   logic [rlm_pkg::FLOOR_W-1:0]         floor_ff, floor_in;
   logic                                known_ff, known_in;
   logic [rlm_pkg::THRESH_W-1:0]        thresh_ff, thresh_in;
   logic [rlm_pkg::ENV_W-1:0]           target_ff, target_in;
   logic [rlm_pkg::ENV_W-1:0]           env_ff, env_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [rlm_pkg::LEVEL_W-1:0]         level_ff, level_in;
   logic [rlm_pkg::OUT20_W-1:0]         mean20_ff, mean20_in;
   logic [rlm_pkg::OUT20_W-1:0]         floorlv_ff, floorlv_in;

   rlm_pkg::mul_req_type mul_req;
   rlm_pkg::mul_rsp_type mul_rsp;
   rlm_pkg::div_rsp_type div_rsp;
   logic                 div_start;

   rlm_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   rlm_div #(.DVS_W(CNT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .rsp      (div_rsp)
   );

   // filter datapath
   logic signed [rlm_pkg::SAMPLE_W:0]   dx;
   logic signed [rlm_pkg::FILT_W+1:0]   y_wide;
   logic signed [rlm_pkg::FILT_W-1:0]   y_sat;
   logic signed [rlm_pkg::FILT_W:0]     pf_ext;
   logic signed [rlm_pkg::FILT_W:0]     pf_neg;
   logic [rlm_pkg::MAG_W-1:0]           mag;
   logic [rlm_pkg::SUM_W:0]             sum_add;
   logic [rlm_pkg::SUM_W-1:0]           sum_sat;

   assign dx     = rlm_pkg::SAMPLE_W'(1)'(0) + ({x_ff[rlm_pkg::SAMPLE_W-1], x_ff}
                 - {prev_input_ff[rlm_pkg::SAMPLE_W-1], prev_input_ff});
   assign y_wide = ((rlm_pkg::FILT_W+2)'(dx) <<< 8)
                 + (rlm_pkg::FILT_W+2)'(mul_rsp.value[rlm_pkg::FILT_W+1:0]);
   always_comb begin
      if (y_wide > (rlm_pkg::FILT_W+2)'(33'sh0_7FFF_FFFF))
         y_sat = {1'b0, {(rlm_pkg::FILT_W-1){1'b1}}};
      else if (y_wide < -(rlm_pkg::FILT_W+2)'(33'sh0_8000_0000))
         y_sat = {1'b1, {(rlm_pkg::FILT_W-1){1'b0}}};
      else
         y_sat = y_wide[rlm_pkg::FILT_W-1:0];
   end
   assign pf_ext  = (rlm_pkg::FILT_W+1)'(prev_filt_ff);
   assign pf_neg  = -pf_ext;
   assign mag     = pf_ext[rlm_pkg::FILT_W] ? pf_neg[rlm_pkg::MAG_W-1:0]
                                            : pf_ext[rlm_pkg::MAG_W-1:0];
   assign sum_add = {1'b0, sum_ff} + (rlm_pkg::SUM_W+1)'(mag);
   assign sum_sat = sum_add[rlm_pkg::SUM_W] ? '1 : sum_add[rlm_pkg::SUM_W-1:0];

   // chunk-end datapath
   logic [rlm_pkg::FLOOR_W-1:0]        fmean;
   logic [rlm_pkg::FLOOR_W-1:0]        floor_eff;
   logic signed [rlm_pkg::FLOOR_W:0]   fdiff;
   logic [rlm_pkg::COEF_W-1:0]         floor_rate;
   logic [rlm_pkg::FLOOR_W-1:0]        floor_next;
   logic [rlm_pkg::THRESH_W-1:0]       thresh_next;
   logic signed [rlm_pkg::SUM_W+1:0]   tdiff;
   logic                               tdiff_pos;
   logic [rlm_pkg::MAG_W-1:0]          tdiff_sat;
   logic [rlm_pkg::ENV_W-1:0]          target_next;
   logic [rlm_pkg::RATE_W-1:0]         env_rate_raw;
   logic [rlm_pkg::RATE_W-1:0]         env_rate;
   logic signed [rlm_pkg::ENV_W:0]     ediff;
   logic signed [19:0]                 env_sum;
   logic [rlm_pkg::ENV_W-1:0]          env_next;
   logic [rlm_pkg::ENV_W-1:0]          env_rnd;

   assign fmean      = (|mean_ff[rlm_pkg::SUM_W-1:rlm_pkg::FLOOR_W]) ? '1
                                                         : mean_ff[rlm_pkg::FLOOR_W-1:0];
   assign floor_eff  = known_ff ? floor_ff : fmean;
   assign fdiff      = $signed({1'b0, fmean}) - $signed({1'b0, floor_eff});
   assign floor_rate = fdiff[rlm_pkg::FLOOR_W] ? fall_rate_ff : rise_rate_ff;
   assign floor_next = floor_ff + mul_rsp.value[rlm_pkg::FLOOR_W-1:0];
   assign thresh_next = rlm_pkg::THRESH_W'(mul_rsp.value[rlm_pkg::THRESH_W-1:0])
                      + rlm_pkg::THRESH_W'({offset_ff, 8'h00});
   assign tdiff      = $signed({2'b00, mean_ff})
                     - $signed({{(rlm_pkg::SUM_W+2-rlm_pkg::THRESH_W){1'b0}}, thresh_ff});
   assign tdiff_pos  = !tdiff[rlm_pkg::SUM_W+1] && (tdiff != '0);
   assign tdiff_sat  = (|tdiff[rlm_pkg::SUM_W:rlm_pkg::MAG_W]) ? '1
                                                               : tdiff[rlm_pkg::MAG_W-1:0];
   assign target_next = (mul_rsp.value > rlm_pkg::MUL_R_W'(rlm_pkg::TARGET_MAX))
                      ? rlm_pkg::TARGET_MAX : mul_rsp.value[rlm_pkg::ENV_W-1:0];
   assign env_rate_raw = (target_ff > env_ff) ? attack_ff : release_ff;
   assign env_rate   = env_rate_raw[rlm_pkg::RATE_W-1] ? rlm_pkg::RATE_ONE : env_rate_raw;
   assign ediff      = $signed({1'b0, target_ff}) - $signed({1'b0, env_ff});
   assign env_sum    = $signed({4'b0000, env_ff}) + $signed(mul_rsp.value[19:0]);
   always_comb begin
      if (env_sum[19])
         env_next = '0;
      else if (env_sum > $signed({4'b0000, rlm_pkg::TARGET_MAX}))
         env_next = rlm_pkg::TARGET_MAX;
      else
         env_next = env_sum[rlm_pkg::ENV_W-1:0];
   end
   assign env_rnd = env_ff + rlm_pkg::LEVEL_RND;

   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      last_in       = last_ff;
      prev_input_in = prev_input_ff;
      prev_filt_in  = prev_filt_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      mean_in       = mean_ff;
      floor_in      = floor_ff;
      known_in      = known_ff;
      thresh_in     = thresh_ff;
      target_in     = target_ff;
      env_in        = env_ff;
      rsp_valid_in  = rsp_valid_ff;
      level_in      = level_ff;
      mean20_in     = mean20_ff;
      floorlv_in    = floorlv_ff;
      mul_req       = '0;
      div_start     = 1'b0;
      if (rsp_valid_ff && !rsp_stall)
         rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in            = req_sample;
               last_in         = req_last_in_chunk;
               mul_req.start   = 1'b1;
               mul_req.shift16 = 1'b1;
               mul_req.a       = rlm_pkg::MUL_A_W'(prev_filt_ff);
               mul_req.b       = $signed({2'b00, hp_coeff_ff});
               state_in        = ST_FILT;
            end
         end
         ST_FILT: begin
            if (mul_rsp.valid) begin
               prev_filt_in  = y_sat;
               prev_input_in = x_ff;
               state_in      = ST_ACC;
            end
         end
         ST_ACC: begin
            if (count_ff < CNT_W'(MAX_CHUNK)) begin
               sum_in   = sum_sat;
               count_in = count_ff + 1'b1;
            end
            state_in = last_ff ? ST_DIVS : ST_IDLE;
         end
         ST_DIVS: begin
            div_start = 1'b1;
            sum_in    = '0;
            count_in  = '0;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               mean_in  = div_rsp.quotient;
               state_in = ST_FLOOR;
            end
         end
         ST_FLOOR: begin
            floor_in        = floor_eff;
            known_in        = 1'b1;
            mul_req.start   = 1'b1;
            mul_req.shift16 = 1'b1;
            mul_req.a       = rlm_pkg::MUL_A_W'(fdiff);
            mul_req.b       = $signed({2'b00, floor_rate});
            state_in        = ST_FLOORW;
         end
         ST_FLOORW: begin
            if (mul_rsp.valid) begin
               floor_in = floor_next;
               state_in = ST_THR;
            end
         end
         ST_THR: begin
            mul_req.start   = 1'b1;
            mul_req.shift16 = 1'b0;
            mul_req.a       = $signed({{(rlm_pkg::MUL_A_W-rlm_pkg::FLOOR_W){1'b0}}, floor_ff});
            mul_req.b       = $signed({2'b00, floor_mult_ff});
            state_in        = ST_THRW;
         end
         ST_THRW: begin
            if (mul_rsp.valid) begin
               thresh_in = thresh_next;
               state_in  = ST_TGT;
            end
         end
         ST_TGT: begin
            if (tdiff_pos) begin
               mul_req.start   = 1'b1;
               mul_req.shift16 = 1'b1;
               mul_req.a       = $signed({1'b0, tdiff_sat});
               mul_req.b       = $signed({2'b00, gain_ff});
               state_in        = ST_TGTW;
            end else begin
               target_in = '0;
               state_in  = ST_ENV;
            end
         end
         ST_TGTW: begin
            if (mul_rsp.valid) begin
               target_in = target_next;
               state_in  = ST_ENV;
            end
         end
         ST_ENV: begin
            mul_req.start   = 1'b1;
            mul_req.shift16 = 1'b1;
            mul_req.a       = rlm_pkg::MUL_A_W'(ediff);
            mul_req.b       = $signed({1'b0, env_rate});
            state_in        = ST_ENVW;
         end
         ST_ENVW: begin
            if (mul_rsp.valid) begin
               env_in   = env_next;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               level_in     = env_rnd[rlm_pkg::ENV_W-1:8];
               mean20_in    = (|mean_ff[rlm_pkg::SUM_W-1:rlm_pkg::FLOOR_W]) ? '1
                            : mean_ff[rlm_pkg::FLOOR_W-1:8];
               floorlv_in   = floor_ff[rlm_pkg::FLOOR_W-1:8];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prev_input_ff <= '0;
         prev_filt_ff  <= '0;
         sum_ff        <= '0;
         count_ff      <= '0;
         floor_ff      <= '0;
         known_ff      <= 1'b0;
         env_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_input_ff <= prev_input_in;
         prev_filt_ff  <= prev_filt_in;
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         floor_ff      <= floor_in;
         known_ff      <= known_in;
         env_ff        <= env_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      x_ff       <= x_in;
      last_ff    <= last_in;
      mean_ff    <= mean_in;
      thresh_ff  <= thresh_in;
      target_ff  <= target_in;
      level_ff   <= level_in;
      mean20_ff  <= mean20_in;
      floorlv_ff <= floorlv_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_level          = level_ff;
   assign rsp_mean_magnitude = mean20_ff;
   assign rsp_floor_level    = floorlv_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_CHUNK))
      else $error("sample count above chunk limit");

   a_env_bound: assert property (@(posedge clock) disable iff (reset)
      env_ff <= rlm_pkg::TARGET_MAX)
      else $error("envelope out of range");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV)
      else $error("divider result outside divide wait");

   a_mul_valid: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.valid |-> (state_ff == ST_FILT || state_ff == ST_FLOORW ||
                         state_ff == ST_THRW || state_ff == ST_TGTW ||
                         state_ff == ST_ENVW))
      else $error("multiplier result outside a wait state");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result raised outside output state");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import rlm_pkg::*;

   localparam int MAX_CHUNK      = 256;
   localparam int SETTLE_CYCLES  = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 90;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   localparam longint FILT_HI     = longint'(32'h7FFF_FFFF);
   localparam longint FILT_LO     = -longint'(32'h8000_0000);
   localparam longint SUM_LIMIT   = (longint'(1) << SUM_W) - 1;
   localparam longint FLOOR_LIMIT = (longint'(1) << FLOOR_W) - 1;
   localparam longint OUT20_LIMIT = (longint'(1) << OUT20_W) - 1;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [OUT20_W-1:0] mean_magnitude;
      logic [OUT20_W-1:0] floor_level;
   } meter_reading_t;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       req_last_in_chunk;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [LEVEL_W-1:0]         rsp_level;
   logic [OUT20_W-1:0]         rsp_mean_magnitude;
   logic [OUT20_W-1:0]         rsp_floor_level;
   logic                       csr_wr_en;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;

   // register mirror
   logic [COEF_W-1:0] hp_coeff;
   logic [COEF_W-1:0] fall_step;
   logic [COEF_W-1:0] rise_step;
   logic [COEF_W-1:0] floor_gain;
   logic [COEF_W-1:0] floor_margin;
   logic [COEF_W-1:0] level_scale;
   logic [RATE_W-1:0] attack_step;
   logic [RATE_W-1:0] release_step;

   // meter state
   logic signed [SAMPLE_W-1:0] hp_prev_in;
   logic signed [FILT_W-1:0]   hp_prev_out;
   logic [SUM_W-1:0]           chunk_sum;
   int                         chunk_len;
   logic [FLOOR_W-1:0]         floor_q8;
   logic                       floor_seen;
   logic [ENV_W-1:0]           envelope_q8;

   meter_reading_t expected_readings[$];
   int             mismatches;
   int             quiet_cycles;
   int             send_idle_pct;
   int             recv_stall_pct;

   music_ring_level_meter #(
      .MAX_CHUNK(MAX_CHUNK)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .req_last_in_chunk  (req_last_in_chunk),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_level          (rsp_level),
      .rsp_mean_magnitude (rsp_mean_magnitude),
      .rsp_floor_level    (rsp_floor_level),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   function automatic longint round_shr(input longint p, input int sh);
      return (p + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function automatic void reset_meter_model();
      hp_coeff     = RST_HIGHPASS_COEFF;
      fall_step    = RST_FLOOR_FALL_RATE;
      rise_step    = RST_FLOOR_RISE_RATE;
      floor_gain   = RST_FLOOR_MULTIPLIER;
      floor_margin = RST_THRESHOLD_OFFSET;
      level_scale  = RST_LEVEL_GAIN;
      attack_step  = RST_ATTACK_RATE;
      release_step = RST_RELEASE_RATE;
      hp_prev_in   = '0;
      hp_prev_out  = '0;
      chunk_sum    = '0;
      chunk_len    = 0;
      floor_q8     = '0;
      floor_seen   = 1'b0;
      envelope_q8  = '0;
   endfunction

   // returns 1 when the sample closes a chunk and a reading is due
   function automatic bit predict_reading(input logic signed [SAMPLE_W-1:0] s,
                                          input logic last, output meter_reading_t r);
      longint y, acc, mean, fmean, flr, thr, diff, tgt, rate, env;
      r = '0;
      y = (longint'(s) - longint'(hp_prev_in)) * 256
          + round_shr(longint'(hp_coeff) * longint'(hp_prev_out), SHIFT_RATE);
      if (y > FILT_HI) y = FILT_HI;
      if (y < FILT_LO) y = FILT_LO;
      hp_prev_in  = s;
      hp_prev_out = y[FILT_W-1:0];

      if (chunk_len < MAX_CHUNK) begin
         acc = longint'(chunk_sum) + ((y < 0) ? -y : y);
         if (acc > SUM_LIMIT) acc = SUM_LIMIT;
         chunk_sum = acc[SUM_W-1:0];
         chunk_len++;
      end
      if (!last) return 1'b0;

      mean = longint'(chunk_sum) / longint'(chunk_len);
      chunk_sum = '0;
      chunk_len = 0;

      fmean = (mean > FLOOR_LIMIT) ? FLOOR_LIMIT : mean;
      if (!floor_seen) begin
         floor_q8   = fmean[FLOOR_W-1:0];
         floor_seen = 1'b1;
      end
      flr  = longint'(floor_q8);
      rate = (fmean < flr) ? longint'(fall_step) : longint'(rise_step);
      flr += round_shr((fmean - flr) * rate, SHIFT_RATE);
      floor_q8 = flr[FLOOR_W-1:0];

      thr  = round_shr(flr * longint'(floor_gain), SHIFT_MULT) + longint'(floor_margin) * 256;
      diff = mean - thr;
      if (diff <= 0) begin
         tgt = 0;
      end else begin
         tgt = round_shr(diff * longint'(level_scale), SHIFT_RATE);
         if (tgt > longint'(TARGET_MAX)) tgt = longint'(TARGET_MAX);
      end

      env  = longint'(envelope_q8);
      rate = (tgt > env) ? longint'(attack_step) : longint'(release_step);
      if (rate > longint'(RATE_ONE)) rate = longint'(RATE_ONE);
      env += round_shr((tgt - env) * rate, SHIFT_RATE);
      if (env < 0) env = 0;
      if (env > longint'(TARGET_MAX)) env = longint'(TARGET_MAX);
      envelope_q8 = env[ENV_W-1:0];

      env  = (env + 128) >>> 8;
      mean = mean >>> 8;
      if (mean > OUT20_LIMIT) mean = OUT20_LIMIT;
      r.level          = env[LEVEL_W-1:0];
      r.mean_magnitude = mean[OUT20_W-1:0];
      r.floor_level    = flr[8 +: OUT20_W];
      return 1'b1;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      logic signed [SAMPLE_W-1:0] s;
      case ($urandom_range(7))
         0:       s = SAMPLE_MAX;
         1:       s = SAMPLE_MIN;
         2, 3:    s = $urandom_range(0, 64) - 32;
         default: s = $urandom_range(0, 65535);
      endcase
      return s;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_setting();
      case ($urandom_range(5))
         0:       return '0;
         1:       return {1'b0, {COEF_W{1'b1}}};
         2:       return RATE_ONE;
         default: return $urandom_range(0, (1 << CSR_DATA_W) - 1);
      endcase
   endfunction

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_HIGHPASS_COEFF:   hp_coeff     = value[COEF_W-1:0];
         CSR_FLOOR_FALL_RATE:  fall_step    = value[COEF_W-1:0];
         CSR_FLOOR_RISE_RATE:  rise_step    = value[COEF_W-1:0];
         CSR_FLOOR_MULTIPLIER: floor_gain   = value[COEF_W-1:0];
         CSR_THRESHOLD_OFFSET: floor_margin = value[COEF_W-1:0];
         CSR_LEVEL_GAIN:       level_scale  = value[COEF_W-1:0];
         CSR_ATTACK_RATE:      attack_step  = value;
         CSR_RELEASE_RATE:     release_step = value;
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [CSR_DATA_W-1:0] hp, input logic [CSR_DATA_W-1:0] fall,
                                input logic [CSR_DATA_W-1:0] rise,
                                input logic [CSR_DATA_W-1:0] mult,
                                input logic [CSR_DATA_W-1:0] offset,
                                input logic [CSR_DATA_W-1:0] gain,
                                input logic [CSR_DATA_W-1:0] attack,
                                input logic [CSR_DATA_W-1:0] release_val);
      write_csr(CSR_HIGHPASS_COEFF, hp);
      write_csr(CSR_FLOOR_FALL_RATE, fall);
      write_csr(CSR_FLOOR_RISE_RATE, rise);
      write_csr(CSR_FLOOR_MULTIPLIER, mult);
      write_csr(CSR_THRESHOLD_OFFSET, offset);
      write_csr(CSR_LEVEL_GAIN, gain);
      write_csr(CSR_ATTACK_RATE, attack);
      write_csr(CSR_RELEASE_RATE, release_val);
   endtask

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
      meter_reading_t r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_sample        <= s;
      req_last_in_chunk <= last;
      do @(posedge clock); while (req_stall);
      if (predict_reading(s, last, r)) expected_readings.push_back(r);
      @(negedge clock);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // reset values; first chunk seeds the floor, then silence and a quiet chunk
   task automatic test_reset_defaults();
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1);
      send_sample(16'sd0, 1'b1);
      send_sample(16'sd100, 1'b0);
      send_sample(-16'sd100, 1'b0);
      send_sample(16'sd50, 1'b1);
      pause_until_drained();
   endtask

   // saturated target, attack above one, frozen and snapping release
   task automatic test_level_extremes();
      load_settings(17'h1FFFF, 17'h0FFFF, 17'h1FFFF, '0, '0, 17'h0FFFF, 17'h1FFFF, '0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1);
      send_sample(16'sd0, 1'b1);
      pause_until_drained();
      load_settings('0, '0, '0, 17'h0FFFF, 17'h1FFFF, '0, '0, RATE_ONE);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);
      send_sample(16'sd1, 1'b1);
      send_sample(-16'sd1, 1'b1);
      pause_until_drained();
   endtask

   // samples past MAX_CHUNK are filtered but not summed
   task automatic test_overlong_chunk();
      load_settings(RST_HIGHPASS_COEFF, RST_FLOOR_FALL_RATE, RST_FLOOR_RISE_RATE,
                    RST_FLOOR_MULTIPLIER, RST_THRESHOLD_OFFSET, RST_LEVEL_GAIN,
                    RST_ATTACK_RATE, RST_RELEASE_RATE);
      for (int i = 0; i < MAX_CHUNK + 16; i++) send_sample(pick_sample(), i == MAX_CHUNK + 15);
      pause_until_drained();
   endtask

   task automatic test_random_chunks(input int sender_pct, input int receiver_pct);
      int sent;
      int len;
      send_idle_pct  = sender_pct;
      recv_stall_pct = receiver_pct;
      load_settings(pick_setting(), pick_setting(), pick_setting(), pick_setting(),
                    pick_setting(), pick_setting(), pick_setting(), pick_setting());
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         len = $urandom_range(1, 12);
         for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
         sent += len;
      end
      pause_until_drained();
   endtask

   always @(posedge clock) begin : check_readings
      meter_reading_t want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               $display("%0t: reading expected none, got level %0d mean %0d floor %0d",
                        $time, rsp_level, rsp_mean_magnitude, rsp_floor_level);
               mismatches++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_level !== want.level) begin
                  $display("%0t: level expected %0d, got %0d", $time, want.level, rsp_level);
                  mismatches++;
               end
               if (rsp_mean_magnitude !== want.mean_magnitude) begin
                  $display("%0t: mean_magnitude expected %0d, got %0d",
                           $time, want.mean_magnitude, rsp_mean_magnitude);
                  mismatches++;
               end
               if (rsp_floor_level !== want.floor_level) begin
                  $display("%0t: floor_level expected %0d, got %0d",
                           $time, want.floor_level, rsp_floor_level);
                  mismatches++;
               end
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, %0d readings outstanding", $time, expected_readings.size());
            $display("music_ring_level_meter test failed");
            $finish;
         end
      end
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_sample        = '0;
      req_last_in_chunk = 1'b0;
      rsp_stall         = 1'b0;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_HIGHPASS_COEFF;
      csr_wdata         = '0;
      send_idle_pct     = 9;
      recv_stall_pct    = 46;
      mismatches        = 0;
      quiet_cycles      = 0;
      reset_meter_model();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_level_extremes();
      test_overlong_chunk();
      test_random_chunks(9, 46);
      test_random_chunks(46, 9);
      test_random_chunks(0, 0);

      if (mismatches == 0 && expected_readings.size() == 0) begin
         $display("music_ring_level_meter test passed");
      end else begin
         $display("music_ring_level_meter test failed");
      end
      $finish;
   end

endmodule
